FILE: design/lpfp_pkg.sv
package lpfp_pkg;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int POINT_IDX_W = 4;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_POINTS_PER_FRAME = 12;

  // frame layout ahead of and after the point block
  localparam int POINTS_START = 6;
  localparam int TAIL_BYTES   = 4;

  localparam logic [BYTE_W-1:0] HEADER_RST = 8'd84;
  localparam logic [BYTE_W-1:0] LENGTH_RST = 8'd44;
  localparam logic [BYTE_W-1:0] POLY_RST   = 8'd77;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_POLY   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  // sub-field of a point triple
  typedef enum logic [1:0] {
    PH_DIST_LO = 2'd0,
    PH_DIST_HI = 2'd1,
    PH_CONF    = 2'd2,
    PH_UNUSED  = 2'd3
  } pt_phase_t;

  // frame-wide fields handed to the emitter with a load strobe
  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] scan_speed;
    logic [WORD_W-1:0] first_angle;
    logic [WORD_W-1:0] last_angle;
    logic [WORD_W-1:0] stamp;
  } frame_info_t;

endpackage

FILE: design/lpfp_if.sv
interface lpfp_byte_if;
  logic                        valid;
  logic                        ready;
  logic [lpfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfp_point_if;
  logic                             valid;
  logic                             ready;
  logic [lpfp_pkg::POINT_IDX_W-1:0] point_index;
  logic [lpfp_pkg::WORD_W-1:0]      distance;
  logic [lpfp_pkg::BYTE_W-1:0]      confidence;
  logic [lpfp_pkg::WORD_W-1:0]      scan_speed;
  logic [lpfp_pkg::WORD_W-1:0]      first_angle;
  logic [lpfp_pkg::WORD_W-1:0]      last_angle;
  logic [lpfp_pkg::WORD_W-1:0]      stamp;
  logic                             last_point;

  modport source (output valid, output point_index, output distance, output confidence,
                  output scan_speed, output first_angle, output last_angle, output stamp,
                  output last_point, input ready);
  modport sink   (input valid, input point_index, input distance, input confidence,
                  input scan_speed, input first_angle, input last_angle, input stamp,
                  input last_point, output ready);
endinterface

FILE: design/lidar_point_frame_parser_unit.sv
// channel     dir  payload                                      transaction
// in_byte     in   rx_byte                                      one received byte
// out_point   out  point_index, distance, confidence, speed,    one point of a frame
//                  first/last angle, stamp, last_point
// cfg_*       in   cfg_index, cfg_data                          register write, no wait
//
// one byte is taken per ready cycle; parse and crc update sit between the byte and the
// frame registers. a good checksum byte loads a frame snapshot, which sends
// POINTS_PER_FRAME points, one per out_point transaction, while the next frame parses.
// in_byte stalls only on a checksum byte that arrives while the snapshot is still sending.
// synchronous active-low reset restores registers and returns the parser to idle.
module lidar_point_frame_parser_unit #(
  parameter int POINTS_PER_FRAME = lpfp_pkg::DEF_POINTS_PER_FRAME
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lpfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpfp_pkg::BYTE_W-1:0]    cfg_data,
  lpfp_byte_if.sink                      in_byte,
  lpfp_point_if.source                   out_point
);
  import lpfp_pkg::*;

  localparam int POINTS_END = POINTS_START + 3 * POINTS_PER_FRAME;
  localparam int CRC_POS    = POINTS_END + TAIL_BYTES;
  localparam int POS_W      = $clog2(CRC_POS + 1);
  localparam int PT_W       = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;

  localparam logic [POS_W-1:0] P_HDR   = POS_W'(0);
  localparam logic [POS_W-1:0] P_LEN   = POS_W'(1);
  localparam logic [POS_W-1:0] P_SPDL  = POS_W'(2);
  localparam logic [POS_W-1:0] P_SPDH  = POS_W'(3);
  localparam logic [POS_W-1:0] P_STAL  = POS_W'(4);
  localparam logic [POS_W-1:0] P_STAH  = POS_W'(5);
  localparam logic [POS_W-1:0] P_ENDL  = POS_W'(POINTS_END);
  localparam logic [POS_W-1:0] P_ENDH  = POS_W'(POINTS_END + 1);
  localparam logic [POS_W-1:0] P_STML  = POS_W'(POINTS_END + 2);
  localparam logic [POS_W-1:0] P_CRC   = POS_W'(CRC_POS);

  logic [BYTE_W-1:0] hdr_r, len_r, poly_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt, crc_upd;
  logic [PT_W-1:0]   pt_r, pt_nxt;
  pt_phase_t         phase_r, phase_nxt;
  logic [WORD_W-1:0] speed_r, speed_nxt, start_r, start_nxt;
  logic [WORD_W-1:0] end_r, end_nxt, stamp_r, stamp_nxt;
  logic [WORD_W-1:0] dist_r [POINTS_PER_FRAME];
  logic [BYTE_W-1:0] conf_r [POINTS_PER_FRAME];
  logic              dist_lo_we, dist_hi_we, conf_we;
  logic              accept, emit_busy;
  logic [BYTE_W-1:0] b;
  frame_info_t       info;

  assign b             = in_byte.rx_byte;
  assign in_byte.ready = (pos_r != P_CRC) || !emit_busy;
  assign accept        = in_byte.valid && in_byte.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= HEADER_RST;
      len_r  <= LENGTH_RST;
      poly_r <= POLY_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEADER: hdr_r  <= cfg_data;
        CFG_LENGTH: len_r  <= cfg_data;
        CFG_POLY:   poly_r <= cfg_data;
        default: ;
      endcase
    end
  end

  lpfp_crc8 u_crc (
    .crc_i  (crc_r),
    .data_i (b),
    .poly_i (poly_r),
    .crc_o  (crc_upd)
  );

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    pt_nxt     = pt_r;
    phase_nxt  = phase_r;
    speed_nxt  = speed_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    stamp_nxt  = stamp_r;
    dist_lo_we = 1'b0;
    dist_hi_we = 1'b0;
    conf_we    = 1'b0;
    info.load        = 1'b0;
    info.scan_speed  = speed_r;
    info.first_angle = start_r;
    info.last_angle  = end_r;
    info.stamp       = stamp_r;
    if (accept) begin
      pos_nxt = pos_r + 1'b1;
      crc_nxt = crc_upd;
      if (pos_r == P_CRC) begin
        info.load = (b == crc_r);
        pos_nxt   = '0;
        crc_nxt   = '0;
        pt_nxt    = '0;
        phase_nxt = PH_DIST_LO;
      end else if ((pos_r == P_HDR && b != hdr_r) || (pos_r == P_LEN && b != len_r)) begin
        // bad header or length: drop back to idle without re-checking this byte
        pos_nxt   = '0;
        crc_nxt   = '0;
        pt_nxt    = '0;
        phase_nxt = PH_DIST_LO;
      end else if (pos_r == P_SPDL) begin
        speed_nxt = {speed_r[WORD_W-1:BYTE_W], b};
      end else if (pos_r == P_SPDH) begin
        speed_nxt = {b, speed_r[BYTE_W-1:0]};
      end else if (pos_r == P_STAL) begin
        start_nxt = {start_r[WORD_W-1:BYTE_W], b};
      end else if (pos_r == P_STAH) begin
        start_nxt = {b, start_r[BYTE_W-1:0]};
      end else if (pos_r > P_STAH && pos_r < P_ENDL) begin
        case (phase_r)
          PH_DIST_LO: begin
            dist_lo_we = 1'b1;
            phase_nxt  = PH_DIST_HI;
          end
          PH_DIST_HI: begin
            dist_hi_we = 1'b1;
            phase_nxt  = PH_CONF;
          end
          PH_CONF: begin
            conf_we   = 1'b1;
            pt_nxt    = pt_r + 1'b1;
            phase_nxt = PH_DIST_LO;
          end
          default: phase_nxt = PH_DIST_LO;
        endcase
      end else if (pos_r == P_ENDL) begin
        end_nxt = {end_r[WORD_W-1:BYTE_W], b};
      end else if (pos_r == P_ENDH) begin
        end_nxt = {b, end_r[BYTE_W-1:0]};
      end else if (pos_r == P_STML) begin
        stamp_nxt = {stamp_r[WORD_W-1:BYTE_W], b};
      end else if (pos_r != P_HDR && pos_r != P_LEN) begin
        stamp_nxt = {b, stamp_r[BYTE_W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      crc_r   <= '0;
      pt_r    <= '0;
      phase_r <= PH_DIST_LO;
      speed_r <= '0;
      start_r <= '0;
      end_r   <= '0;
      stamp_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      pt_r    <= pt_nxt;
      phase_r <= phase_nxt;
      speed_r <= speed_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dist_lo_we) begin
      dist_r[pt_r][BYTE_W-1:0] <= b;
    end
    if (dist_hi_we) begin
      dist_r[pt_r][WORD_W-1:BYTE_W] <= b;
    end
    if (conf_we) begin
      conf_r[pt_r] <= b;
    end
  end

  lpfp_emit #(
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .info_i    (info),
    .dist_i    (dist_r),
    .conf_i    (conf_r),
    .busy_o    (emit_busy),
    .out_point (out_point)
  );

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == P_CRC) |-> !out_point.valid)
    else $error("checksum byte taken while points still sending");

  a_frame_ends_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_point.valid && out_point.ready && out_point.last_point) |=> !out_point.valid)
    else $error("point output continues past last point");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= P_CRC)
    else $error("byte position beyond checksum");

  a_bad_header_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && pos_r == P_HDR && b != hdr_r) |=> (pos_r == P_HDR && crc_r == '0))
    else $error("parser left idle on wrong header byte");

endmodule

FILE: design/lpfp_crc8.sv
module lpfp_crc8 (
  input  logic [lpfp_pkg::BYTE_W-1:0] crc_i,
  input  logic [lpfp_pkg::BYTE_W-1:0] data_i,
  input  logic [lpfp_pkg::BYTE_W-1:0] poly_i,
  output logic [lpfp_pkg::BYTE_W-1:0] crc_o
);
  import lpfp_pkg::*;

  // msb-first, one bit per step
  always_comb begin
    logic [BYTE_W-1:0] c;
    c = crc_i ^ data_i;
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ poly_i;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

FILE: design/lpfp_emit.sv
module lpfp_emit #(
  parameter int POINTS_PER_FRAME = lpfp_pkg::DEF_POINTS_PER_FRAME
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpfp_pkg::frame_info_t       info_i,
  input  logic [lpfp_pkg::WORD_W-1:0] dist_i [POINTS_PER_FRAME],
  input  logic [lpfp_pkg::BYTE_W-1:0] conf_i [POINTS_PER_FRAME],
  output logic                        busy_o,
  lpfp_point_if.source                out_point
);
  import lpfp_pkg::*;

  localparam int IDX_W = (POINTS_PER_FRAME > 1) ? $clog2(POINTS_PER_FRAME) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_FRAME - 1);

  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] dist_r [POINTS_PER_FRAME];
  logic [BYTE_W-1:0] conf_r [POINTS_PER_FRAME];
  logic [WORD_W-1:0] speed_r, start_r, end_r, stamp_r;
  logic [IDX_W+POINT_IDX_W-1:0] idx_ext;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (info_i.load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r && out_point.ready) begin
      if (idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        idx_nxt  = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // frame snapshot, so parsing of the next frame can run during emission
  always_ff @(posedge clk) begin
    if (info_i.load) begin
      dist_r  <= dist_i;
      conf_r  <= conf_i;
      speed_r <= info_i.scan_speed;
      start_r <= info_i.first_angle;
      end_r   <= info_i.last_angle;
      stamp_r <= info_i.stamp;
    end
  end

  assign idx_ext = {{POINT_IDX_W{1'b0}}, idx_r};

  assign busy_o                = busy_r;
  assign out_point.valid       = busy_r;
  assign out_point.point_index = idx_ext[POINT_IDX_W-1:0];
  assign out_point.distance    = dist_r[idx_r];
  assign out_point.confidence  = conf_r[idx_r];
  assign out_point.scan_speed  = speed_r;
  assign out_point.first_angle = start_r;
  assign out_point.last_angle  = end_r;
  assign out_point.stamp       = stamp_r;
  assign out_point.last_point  = (idx_r == LAST_IDX);

endmodule
